@@ rtl/core/hitp_pkg.sv @@
// Shared types, character codes and the hex digit decoder for the hex image text parser.
package hitp_pkg;

   localparam int ADDR_W = 32;
   localparam int BYTE_W = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_AT = 8'h40;
   localparam logic [7:0] CHAR_NL = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_ADDR,
      MODE_DATA,
      MODE_SKIP
   } line_mode_type;

   typedef struct packed {
      line_mode_type       mode;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   tok;
      logic                open;
      logic [ADDR_W-1:0]   high;
   } parse_state_type;

   typedef struct packed {
      logic                is_write;
      logic [ADDR_W-1:0]   write_address;
      logic [BYTE_W-1:0]   write_byte;
      logic [ADDR_W-1:0]   highest_address;
      logic                end_of_image;
   } rsp_type;

   typedef struct packed {
      logic       hex;
      logic [3:0] nib;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      logic [7:0]    t;
      r.hex = 1'b0;
      r.nib = 4'd0;
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
         r.hex = 1'b1;
         r.nib = t[3:0];
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
         r.hex = 1'b1;
         r.nib = t[3:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
         r.hex = 1'b1;
         r.nib = t[3:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/hex_image_text_parser.sv @@
// Top level of the hex memory image text parser.
//
// Input channel (req_): one ASCII character of the image per beat, with
// req_final_char set on the last character of the image.
// Result channel (rsp_): byte writes (rsp_is_write=1) at the current
// address, and after the last character one summary beat (rsp_end_of_image=1)
// carrying the highest written address.
// Each character is parsed in the cycle it is accepted; its results are
// written into a four-entry result queue whose registered head drives rsp_.
// One character is taken every cycle while req_ready is high; a character
// yields at most two results (a write and the summary).
// req_ready is high while at most two beats are queued, so a stalled
// receiver holds results in the queue and req_ready falls once three or
// four beats wait; it rises again after the queue drains back to two.
// Reset clears the parser state (line start, address zero, no open token,
// highest address zero) and empties the queue. After the last character
// the parser state returns to these same values.
module hex_image_text_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_character,
   input  logic                          req_final_char,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_is_write,
   output logic [hitp_pkg::ADDR_W-1:0]   rsp_write_address,
   output logic [hitp_pkg::BYTE_W-1:0]   rsp_write_byte,
   output logic [hitp_pkg::ADDR_W-1:0]   rsp_highest_address,
   output logic                          rsp_end_of_image
);

   hitp_pkg::parse_state_type         state_ff, state_in, step_nxt;
   hitp_pkg::rsp_type                 wr_rsp, sum_rsp, head;
   logic                              wr_valid;
   logic                              req_beat;
   logic                              room_two;
   logic [hitp_pkg::QCNT_W-1:0]       q_count;

   assign req_ready = room_two;
   assign req_beat  = req_valid & req_ready;

   hitp_step u_step (
      .cur        (state_ff),
      .character  (req_character),
      .final_char (req_final_char),
      .nxt        (step_nxt),
      .wr_valid   (wr_valid),
      .wr_rsp     (wr_rsp),
      .sum_rsp    (sum_rsp)
   );

   assign state_in = req_beat ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= hitp_pkg::MODE_START;
         state_ff.addr <= '0;
         state_ff.tok  <= '0;
         state_ff.open <= 1'b0;
         state_ff.high <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   hitp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (req_beat & wr_valid),
      .data_a    (wr_rsp),
      .push_b    (req_beat & req_final_char),
      .data_b    (sum_rsp),
      .pop       (rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .room_two  (room_two),
      .count     (q_count)
   );

   assign rsp_is_write        = head.is_write;
   assign rsp_write_address   = head.write_address;
   assign rsp_write_byte      = head.write_byte;
   assign rsp_highest_address = head.highest_address;
   assign rsp_end_of_image    = head.end_of_image;

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= hitp_pkg::QCNT_W'(hitp_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   // last character puts the parser back to its reset state
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_final_char |=> state_ff.mode == hitp_pkg::MODE_START &&
      state_ff.addr == '0 && !state_ff.open && state_ff.high == '0)
      else $error("parser state not cleared after final character");

   // a summary beat is pending after the last character
   a_final_result: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_final_char |=> rsp_valid)
      else $error("no result after final character");

   // open token only exists on a data line
   a_open_on_data: assert property (@(posedge clock) disable iff (reset)
      state_ff.open |-> state_ff.mode == hitp_pkg::MODE_DATA)
      else $error("open token outside data line");

endmodule

@@ rtl/core/hitp_step.sv @@
// One character of parsing: next state, an optional byte write and the end summary.
module hitp_step (
   input  hitp_pkg::parse_state_type cur,
   input  logic [7:0]                character,
   input  logic                      final_char,
   output hitp_pkg::parse_state_type nxt,
   output logic                      wr_valid,
   output hitp_pkg::rsp_type         wr_rsp,
   output hitp_pkg::rsp_type         sum_rsp
);

   hitp_pkg::hex_digit_type          dig;
   hitp_pkg::line_mode_type          mode_mid;
   logic [hitp_pkg::ADDR_W-1:0]      addr_mid;
   logic [hitp_pkg::BYTE_W-1:0]      tok_mid;
   logic                             open_mid;
   logic                             sep_flush;
   logic [hitp_pkg::ADDR_W-1:0]      addr_inc;
   logic [hitp_pkg::ADDR_W-1:0]      high_wr;

   assign dig = hitp_pkg::hex_decode(character);

   always_comb begin
      mode_mid  = cur.mode;
      addr_mid  = cur.addr;
      tok_mid   = cur.tok;
      open_mid  = cur.open;
      sep_flush = 1'b0;
      if (character == hitp_pkg::CHAR_NL) begin
         sep_flush = 1'b1;
         mode_mid  = hitp_pkg::MODE_START;
      end else if (cur.mode == hitp_pkg::MODE_START && character == hitp_pkg::CHAR_AT) begin
         mode_mid = hitp_pkg::MODE_ADDR;
         addr_mid = '0;
      end else begin
         case (cur.mode)
            hitp_pkg::MODE_ADDR: begin
               if (dig.hex) begin
                  addr_mid = {cur.addr[hitp_pkg::ADDR_W-5:0], dig.nib};
               end else begin
                  mode_mid = hitp_pkg::MODE_SKIP;
               end
            end
            hitp_pkg::MODE_START,
            hitp_pkg::MODE_DATA: begin
               mode_mid = hitp_pkg::MODE_DATA;
               if (dig.hex) begin
                  tok_mid  = {cur.tok[3:0], dig.nib};
                  open_mid = 1'b1;
               end else begin
                  sep_flush = 1'b1;
                  if (character == hitp_pkg::CHAR_NUL) mode_mid = hitp_pkg::MODE_SKIP;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // An open token only lives on a data line, so the address is unchanged here.
   assign wr_valid = open_mid & (sep_flush | final_char);
   assign addr_inc = cur.addr + {{(hitp_pkg::ADDR_W-1){1'b0}}, 1'b1};
   assign high_wr  = (addr_inc > cur.high) ? addr_inc - {{(hitp_pkg::ADDR_W-1){1'b0}}, 1'b1}
                                           : cur.high;

   always_comb begin
      wr_rsp.is_write        = 1'b1;
      wr_rsp.write_address   = cur.addr;
      wr_rsp.write_byte      = tok_mid;
      wr_rsp.highest_address = high_wr;
      wr_rsp.end_of_image    = 1'b0;

      sum_rsp.is_write        = 1'b0;
      sum_rsp.write_address   = '0;
      sum_rsp.write_byte      = '0;
      sum_rsp.highest_address = wr_valid ? high_wr : cur.high;
      sum_rsp.end_of_image    = 1'b1;

      if (final_char) begin
         nxt.mode = hitp_pkg::MODE_START;
         nxt.addr = '0;
         nxt.tok  = '0;
         nxt.open = 1'b0;
         nxt.high = '0;
      end else begin
         nxt.mode = mode_mid;
         nxt.addr = wr_valid ? addr_inc : addr_mid;
         nxt.tok  = wr_valid ? '0 : tok_mid;
         nxt.open = wr_valid ? 1'b0 : open_mid;
         nxt.high = wr_valid ? high_wr : cur.high;
      end
   end

endmodule

@@ rtl/core/hitp_rsp_queue.sv @@
// Small result queue that takes up to two beats per cycle and gives one.
module hitp_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_a,
   input  hitp_pkg::rsp_type data_a,
   input  logic              push_b,
   input  hitp_pkg::rsp_type data_b,
   input  logic              pop,
   output hitp_pkg::rsp_type head,
   output logic              not_empty,
   output logic              room_two,
   output logic [hitp_pkg::QCNT_W-1:0] count
);

   hitp_pkg::rsp_type                 mem_ff [hitp_pkg::QUEUE_DEPTH];
   logic [hitp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hitp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hitp_pkg::QPTR_W-1:0]       wr_ptr_next;
   logic [hitp_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic [hitp_pkg::QCNT_W-1:0]       n_push;
   logic                              do_pop;
   hitp_pkg::rsp_type                 first_data;

   assign do_pop      = pop & not_empty;
   assign n_push      = hitp_pkg::QCNT_W'(push_a) + hitp_pkg::QCNT_W'(push_b);
   assign first_data  = push_a ? data_a : data_b;
   assign wr_ptr_next = wr_ptr_ff + {{(hitp_pkg::QPTR_W-1){1'b0}}, 1'b1};
   assign wr_ptr_in   = wr_ptr_ff + n_push[hitp_pkg::QPTR_W-1:0];
   assign rd_ptr_in   = rd_ptr_ff + hitp_pkg::QPTR_W'(do_pop);
   assign count_in    = count_ff + n_push - hitp_pkg::QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a | push_b) mem_ff[wr_ptr_ff] <= first_data;
      if (push_a & push_b) mem_ff[wr_ptr_next] <= data_b;
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= hitp_pkg::QCNT_W'(hitp_pkg::QUEUE_DEPTH - 2));
   assign count     = count_ff;

endmodule

@@ dv/hex_image_text_parser_test.sv @@
// Self-checking testbench for the hex memory image text parser.
`timescale 1ns / 100ps

module hex_image_text_parser_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_CHARS = 300;

   typedef struct {
      logic [7:0] ch;
      logic       fin;
   } text_beat_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_character = 8'd0;
   logic                          req_final_char = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_is_write;
   logic [hitp_pkg::ADDR_W-1:0]   rsp_write_address;
   logic [hitp_pkg::BYTE_W-1:0]   rsp_write_byte;
   logic [hitp_pkg::ADDR_W-1:0]   rsp_highest_address;
   logic                          rsp_end_of_image;

   text_beat_type          pending_text[$];
   hitp_pkg::rsp_type      predicted_results[$];

   // parser state as the predictor tracks it
   hitp_pkg::line_mode_type parse_mode = hitp_pkg::MODE_START;
   logic [31:0]   cur_addr = 32'd0;
   logic [7:0]    tok_val = 8'd0;
   logic          tok_open = 1'b0;
   logic [31:0]   top_addr = 32'd0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int cycle_count = 0;
   int chars_accepted = 0;
   int images_sent = 0;
   int writes_seen = 0;
   int summaries_seen = 0;
   int mismatches = 0;

   hex_image_text_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_character       (req_character),
      .req_final_char      (req_final_char),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_is_write        (rsp_is_write),
      .rsp_write_address   (rsp_write_address),
      .rsp_write_byte      (rsp_write_byte),
      .rsp_highest_address (rsp_highest_address),
      .rsp_end_of_image    (rsp_end_of_image)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, predicted_results.size());
      $display("hex_image_text_parser_test failed");
      $finish;
   end

   // {is_hex, nibble}
   function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
      logic [7:0] t;
      t = 8'd0;
      if (ch >= "0" && ch <= "9") begin
         t = ch - "0";
      end else if (ch >= "a" && ch <= "f") begin
         t = ch - "a" + 8'd10;
      end else if (ch >= "A" && ch <= "F") begin
         t = ch - "A" + 8'd10;
      end else begin
         return 5'd0;
      end
      return {1'b1, t[3:0]};
   endfunction

   task automatic commit_token();
      hitp_pkg::rsp_type r;
      logic [31:0]       nxt;
      if (tok_open) begin
         r.is_write = 1'b1;
         r.write_address = cur_addr;
         r.write_byte = tok_val;
         r.end_of_image = 1'b0;
         nxt = cur_addr + 32'd1;
         cur_addr = nxt;
         // wrap to zero leaves the high mark alone
         if (nxt > top_addr) top_addr = nxt - 32'd1;
         r.highest_address = top_addr;
         predicted_results.push_back(r);
         tok_open = 1'b0;
         tok_val = 8'd0;
      end
   endtask

   task automatic parse_char(input logic [7:0] ch, input logic fin);
      logic [4:0]        hd;
      logic              consumed;
      hitp_pkg::rsp_type s;
      hd = hex_nibble(ch);
      consumed = 1'b0;
      if (ch == hitp_pkg::CHAR_NL) begin
         commit_token();
         parse_mode = hitp_pkg::MODE_START;
      end else begin
         if (parse_mode == hitp_pkg::MODE_START) begin
            if (ch == hitp_pkg::CHAR_AT) begin
               parse_mode = hitp_pkg::MODE_ADDR;
               cur_addr = 32'd0;
               consumed = 1'b1;
            end else begin
               parse_mode = hitp_pkg::MODE_DATA;
            end
         end
         if (!consumed) begin
            case (parse_mode)
               hitp_pkg::MODE_ADDR: begin
                  if (hd[4]) cur_addr = {cur_addr[27:0], hd[3:0]};
                  else parse_mode = hitp_pkg::MODE_SKIP;
               end
               hitp_pkg::MODE_DATA: begin
                  if (hd[4]) begin
                     tok_val = {tok_val[3:0], hd[3:0]};
                     tok_open = 1'b1;
                  end else begin
                     commit_token();
                     if (ch == hitp_pkg::CHAR_NUL) parse_mode = hitp_pkg::MODE_SKIP;
                  end
               end
               default: ;
            endcase
         end
      end
      if (fin) begin
         commit_token();
         s.is_write = 1'b0;
         s.write_address = '0;
         s.write_byte = '0;
         s.highest_address = top_addr;
         s.end_of_image = 1'b1;
         predicted_results.push_back(s);
         parse_mode = hitp_pkg::MODE_START;
         cur_addr = 32'd0;
         tok_val = 8'd0;
         tok_open = 1'b0;
         top_addr = 32'd0;
      end
   endtask

   // character driver
   always @(posedge clock) begin : char_driver
      text_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_char(req_character, req_final_char);
            chars_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_text.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
               nb = pending_text.pop_front();
               req_character <= nb.ch;
               req_final_char <= nb.fin;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      hitp_pkg::rsp_type want;
      hitp_pkg::rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.is_write = rsp_is_write;
         got.write_address = rsp_write_address;
         got.write_byte = rsp_write_byte;
         got.highest_address = rsp_highest_address;
         got.end_of_image = rsp_end_of_image;
         if (rsp_is_write === 1'b1) writes_seen++;
         else summaries_seen++;
         if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cycle %0d: unexpected beat w=%0b a=%h b=%h hi=%h end=%0b",
                        cycle_count, got.is_write, got.write_address, got.write_byte,
                        got.highest_address, got.end_of_image);
         end else begin
            want = predicted_results.pop_front();
            if (got.is_write !== want.is_write ||
                got.write_address !== want.write_address ||
                got.write_byte !== want.write_byte ||
                got.highest_address !== want.highest_address ||
                got.end_of_image !== want.end_of_image) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("cycle %0d: expected w=%0b a=%h b=%h hi=%h end=%0b",
                           cycle_count, want.is_write, want.write_address,
                           want.write_byte, want.highest_address, want.end_of_image);
                  $display("          got      w=%0b a=%h b=%h hi=%h end=%0b",
                           got.is_write, got.write_address, got.write_byte,
                           got.highest_address, got.end_of_image);
               end
            end
         end
      end
   end

   task automatic push_char(input logic [7:0] ch);
      text_beat_type b;
      b.ch = ch;
      b.fin = 1'b0;
      pending_text.push_back(b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   task automatic end_image();
      pending_text[pending_text.size() - 1].fin = 1'b1;
      images_sent++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return "0" + nib;
      if ($urandom_range(0, 1) == 0) return "a" + nib - 8'd10;
      return "A" + nib - 8'd10;
   endfunction

   // any character that splits tokens: never hex, newline or NUL
   function automatic logic [7:0] sep_char();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         0: return " ";
         1: return "\t";
         2: return "\r";
         3: return ",";
         default: begin
            c = 8'($urandom_range(1, 255));
            while (hex_nibble(c) != 5'd0 || c == hitp_pkg::CHAR_NL)
               c = 8'($urandom_range(1, 255));
            return c;
         end
      endcase
   endfunction

   task automatic build_image();
      int          lines;
      int          kind;
      int          ndig;
      int          ntok;
      int          nch;
      logic [31:0] aval;
      lines = $urandom_range(1, 6);
      for (int ln = 0; ln < lines; ln++) begin
         kind = $urandom_range(0, 99);
         if (kind < 22) begin
            case ($urandom_range(0, 3))
               0: aval = 32'hFFFF_FFF0 | $urandom_range(0, 15);
               1: aval = $urandom;
               default: aval = $urandom_range(0, 255);
            endcase
            // sometimes short, sometimes extra leading digits that shift out
            ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 8;
            push_char(hitp_pkg::CHAR_AT);
            for (int i = ndig - 1; i >= 0; i--)
               push_char(hex_char(i < 8 ? aval[i*4 +: 4] : 4'($urandom_range(0, 15))));
            case ($urandom_range(0, 3))
               0: push_char("\r");
               1: begin
                  push_char(sep_char());
                  push_char(hex_char(4'($urandom_range(0, 15))));
               end
               default: ;
            endcase
            push_char(hitp_pkg::CHAR_NL);
         end else if (kind < 27) begin
            push_char(hitp_pkg::CHAR_NL);
         end else if (kind < 34) begin
            nch = $urandom_range(1, 6);
            repeat (nch) push_char(8'($urandom_range(0, 255)));
            push_char(hitp_pkg::CHAR_NL);
         end else begin
            ntok = $urandom_range(1, 5);
            if ($urandom_range(0, 3) == 0) push_char(sep_char());
            for (int t = 0; t < ntok; t++) begin
               ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(1, 2);
               repeat (ndig) push_char(hex_char(4'($urandom_range(0, 15))));
               if (t < ntok - 1) repeat ($urandom_range(1, 2)) push_char(sep_char());
            end
            if ($urandom_range(0, 19) == 0) begin
               push_char(hitp_pkg::CHAR_NUL);
               repeat ($urandom_range(0, 3)) push_char(hex_char(4'($urandom_range(0, 15))));
            end
            // the last line may end mid-token so the final beat flushes it
            if (ln < lines - 1 || $urandom_range(0, 2) != 0) push_char(hitp_pkg::CHAR_NL);
         end
      end
      end_image();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_text.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   initial begin : stimulus
      int phase_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 29; rx_idle_pct = 52; end
            1: begin tx_idle_pct = 52; rx_idle_pct = 29; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         phase_start = pending_text.size() + chars_accepted;
         if (ph == 0) begin
            // empty line, over-long address ended by CR landing on the top address
            push_char(hitp_pkg::CHAR_NL);
            push_text("@9FFFFFFFF\r\n");
            // write at the top address wraps to zero, CR separates, NUL skips the rest
            push_text("aB\r7");
            push_char(hitp_pkg::CHAR_NUL);
            push_text("5\n");
            // 0xFF separator, long token, '@' mid-line, final on an open token
            push_char(8'hFF);
            push_text("123@e");
            end_image();
            // hold the sender mid-image until all results are back
            push_text("@1c\n0 12 ab");
            wait_drained();
            push_text(" Cd\n");
            end_image();
         end
         while (pending_text.size() + chars_accepted - phase_start < PHASE_CHARS)
            build_image();
         wait_drained();
      end
      repeat (20) @(negedge clock);
      $display("%0d characters in %0d images sent under three idle mixes",
               chars_accepted, images_sent);
      $display("%0d byte writes and %0d image summaries checked, %0d mismatches",
               writes_seen, summaries_seen, mismatches);
      if (mismatches == 0) begin
         $display("hex_image_text_parser_test passed");
      end else begin
         $display("hex_image_text_parser_test failed");
      end
      $finish;
   end

endmodule
